// File: design/substring_line_filter_core_defines.svh
// Assertion macros used by the top level of the substring line filter.
`ifndef SUBSTRING_LINE_FILTER_CORE_DEFINES_SVH
`define SUBSTRING_LINE_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/slf_pkg.sv
// Shared constants, types and helper functions of the substring line filter.
package slf_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int PAT_REG_BYTES = 16;
    localparam int PAT_W         = 8 * PAT_REG_BYTES;
    localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
    localparam int CFG_LEN_W     = 5;
    localparam int MODE_W        = 4;
    localparam int CNT_W         = 32;

    localparam logic [MODE_W-1:0] FLAG_INVERT = MODE_W'(1);
    localparam logic [MODE_W-1:0] FLAG_COUNT  = MODE_W'(2);
    localparam logic [MODE_W-1:0] FLAG_NUMBER = MODE_W'(4);
    localparam logic [MODE_W-1:0] FLAG_ICASE  = MODE_W'(8);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0]       NEWLINE = 8'd10;

    localparam logic CMD_DATA     = 1'b0;
    localparam logic CMD_EOS      = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_PATTERN_LOW    = 2'd0;
    localparam reg_idx_t REG_PATTERN_HIGH   = 2'd1;
    localparam reg_idx_t REG_PATTERN_LENGTH = 2'd2;
    localparam reg_idx_t REG_MODE_FLAGS     = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       fire;
        logic       eos;
        logic [7:0] text_byte;
    } step_t;

    typedef struct packed {
        logic             kind;
        logic             print_line;
        logic             print_number;
        logic [CNT_W-1:0] line_number;
        logic [CNT_W-1:0] match_count;
        logic             print_count;
        logic             exit_status;
        logic             last;
    } result_t;

    typedef struct packed {
        logic                  room;
        logic [FIFO_CNT_W-1:0] count;
    } fifo_status_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && c >= 8'd65 && c <= 8'd90) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                            input logic [LEN_W-1:0] k);
        logic [7:0] r;
        r = '0;
        if (int'(k) < PAT_REG_BYTES) begin
            r = pat[8*int'(k) +: 8];
        end
        return r;
    endfunction

endpackage

// File: design/slf_window.sv
// Window of the most recent bytes of the current line and the parallel pattern compare.
module slf_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  slf_pkg::step_t               step,
    input  logic [slf_pkg::PAT_W-1:0]    pattern,
    input  logic [slf_pkg::LEN_W-1:0]    len_eff,
    input  logic                         icase,
    output logic                         hit
);
    import slf_pkg::*;

    logic [7:0]       win_reg [PATTERN_BYTES];
    logic [7:0]       win_next [PATTERN_BYTES];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic             line_end;
    logic             all_equal;
    logic [LEN_W-1:0] idx;

    assign line_end = step.eos || (step.text_byte == NEWLINE);

    always_comb begin
        win_next[0] = step.text_byte;
        for (int i = 1; i < PATTERN_BYTES; i++) begin
            win_next[i] = win_reg[i-1];
        end
        fill_next = (int'(fill_reg) == PATTERN_BYTES) ? fill_reg : fill_reg + LEN_W'(1);
    end

    always_comb begin
        all_equal = 1'b1;
        idx       = '0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            idx = len_eff - LEN_W'(k + 1);
            if (LEN_W'(k) < len_eff) begin
                if (fold(win_next[k], icase) != fold(pat_byte(pattern, idx), icase)) begin
                    all_equal = 1'b0;
                end
            end
        end
        hit = step.fire && !step.eos && (len_eff != '0) && (fill_next >= len_eff)
              && all_equal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (step.fire) begin
            if (line_end) begin
                fill_reg <= '0;
            end else begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step.fire && !step.eos) begin
            for (int i = 0; i < PATTERN_BYTES; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

// File: design/slf_judge.sv
// Line state, saturating counters and formation of verdict and summary results.
module slf_judge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  slf_pkg::step_t               step,
    input  logic                         hit,
    input  logic                         len_zero,
    input  logic [slf_pkg::MODE_W-1:0]   mode,
    output slf_pkg::result_t             res0,
    output slf_pkg::result_t             res1,
    output logic [1:0]                   npush
);
    import slf_pkg::*;

    logic             found_reg;
    logic             open_reg;
    logic [CNT_W-1:0] lines_reg;
    logic [CNT_W-1:0] sel_reg;

    logic             is_newline;
    logic             found_now;
    logic             show;
    logic             judge;
    logic [CNT_W-1:0] lines_inc;
    logic [CNT_W-1:0] sel_inc;
    logic [CNT_W-1:0] lines_next;
    logic [CNT_W-1:0] sel_next;
    result_t          verdict;
    result_t          summary;

    always_comb begin
        is_newline = !step.eos && (step.text_byte == NEWLINE);
        found_now  = found_reg || hit || len_zero;
        show       = ((mode & FLAG_INVERT) != '0) ? !found_now : found_now;
        judge      = step.fire && (is_newline || (step.eos && open_reg));
        lines_inc  = (lines_reg == CNT_MAX) ? lines_reg : lines_reg + CNT_W'(1);
        sel_inc    = (sel_reg == CNT_MAX) ? sel_reg : sel_reg + CNT_W'(1);
        lines_next = judge ? lines_inc : lines_reg;
        sel_next   = (judge && show) ? sel_inc : sel_reg;

        verdict.kind         = KIND_VERDICT;
        verdict.print_line   = show && ((mode & FLAG_COUNT) == '0);
        verdict.print_number = verdict.print_line && ((mode & FLAG_NUMBER) != '0);
        verdict.line_number  = lines_inc;
        verdict.match_count  = sel_next;
        verdict.print_count  = 1'b0;
        verdict.exit_status  = 1'b0;
        verdict.last         = !step.eos;

        summary.kind         = KIND_SUMMARY;
        summary.print_line   = 1'b0;
        summary.print_number = 1'b0;
        summary.line_number  = lines_next;
        summary.match_count  = sel_next;
        summary.print_count  = (mode & FLAG_COUNT) != '0;
        summary.exit_status  = sel_next == '0;
        summary.last         = 1'b1;

        res0 = (step.eos && !open_reg) ? summary : verdict;
        res1 = summary;

        npush = 2'd0;
        if (step.fire) begin
            if (step.eos) begin
                npush = open_reg ? 2'd2 : 2'd1;
            end else if (is_newline) begin
                npush = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            open_reg  <= 1'b0;
            lines_reg <= '0;
            sel_reg   <= '0;
        end else if (step.fire) begin
            if (step.eos) begin
                found_reg <= 1'b0;
                open_reg  <= 1'b0;
                lines_reg <= '0;
                sel_reg   <= '0;
            end else if (is_newline) begin
                found_reg <= 1'b0;
                open_reg  <= 1'b0;
                lines_reg <= lines_next;
                sel_reg   <= sel_next;
            end else begin
                found_reg <= found_reg || hit;
                open_reg  <= 1'b1;
            end
        end
    end

endmodule

// File: design/slf_fifo.sv
// Small result queue that takes up to two results per cycle and delivers one per beat.
module slf_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slf_pkg::result_t      res0,
    input  slf_pkg::result_t      res1,
    input  logic [1:0]            npush,
    input  logic                  pop,
    output slf_pkg::result_t      head,
    output logic                  head_valid,
    output slf_pkg::fifo_status_t status
);
    import slf_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    always_comb begin
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(npush);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + FIFO_CNT_W'(npush) - FIFO_CNT_W'(pop);
    end

    assign head          = mem_reg[rd_ptr_reg];
    assign head_valid    = count_reg != '0;
    assign status.count  = count_reg;
    assign status.room   = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (npush != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (npush == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= res1;
        end
    end

endmodule

// File: design/substring_line_filter_core.sv
// Top level of the substring line filter: register port, input stage and result channel.
// Usage: text arrives on the s_ channel one byte per beat; s_tuser low carries a data
// byte in s_tdata, s_tuser high marks end of stream. Every newline produces one verdict
// beat on the m_ channel; end of stream produces the verdict of an unterminated line, if
// any, followed by a summary beat, and m_tlast marks the last beat caused by an input.
// The user must write patterns and mode flags over the register port while the block is
// idle; the block does not enforce it. Throughput is one input byte per clock while the
// result queue has room; the window compare is combinational from the input register to
// the result queue, which registers each result. An end of stream with an open line puts
// two beats into the queue in the same cycle, and they leave the queue one at a time.
// If the receiver stalls, the four-entry result queue fills; once it holds more than two
// beats the input register stops advancing and s_tready falls as soon as that register
// holds a beat.
// Reset clears the registers, the line state and both counters, and empties the queue.
`include "substring_line_filter_core_defines.svh"

module substring_line_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    input  logic        s_tuser,  // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // [0] print_line, [1] print_number, [33:2] line_number,
                                  // [65:34] match_count, [66] print_count,
                                  // [67] exit_status, [71:68] zero
    output logic        m_tuser,  // [0] kind
    output logic        m_tlast
);
    import slf_pkg::*;

    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_high_reg;
    logic [CFG_LEN_W-1:0] pat_len_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    logic                 in_valid_reg;
    logic                 in_eos_reg;
    logic [7:0]           in_byte_reg;
    logic                 fire;

    logic [LEN_W-1:0]     len_eff;
    step_t                step;
    logic                 hit;
    result_t              res0;
    result_t              res1;
    logic [1:0]           npush;
    result_t              head;
    fifo_status_t         fifo_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            mode_reg     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PATTERN_LOW:    pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH:   pat_high_reg <= pwdata;
                REG_PATTERN_LENGTH: pat_len_reg  <= pwdata[CFG_LEN_W-1:0];
                REG_MODE_FLAGS:     mode_reg     <= pwdata[MODE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            REG_PATTERN_LENGTH: prdata = 64'(pat_len_reg);
            REG_MODE_FLAGS:     prdata = 64'(mode_reg);
        endcase
    end

    always_comb begin
        if (int'(pat_len_reg) > PATTERN_BYTES) begin
            len_eff = LEN_W'(PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(pat_len_reg);
        end
    end

    assign fire     = in_valid_reg && fifo_stat.room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_eos_reg  <= (s_tuser == CMD_EOS);
            in_byte_reg <= s_tdata;
        end
    end

    assign step.fire      = fire;
    assign step.eos       = in_eos_reg;
    assign step.text_byte = in_byte_reg;

    slf_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pattern ({pat_high_reg, pat_low_reg}),
        .len_eff (len_eff),
        .icase   ((mode_reg & FLAG_ICASE) != '0),
        .hit     (hit)
    );

    slf_judge u_judge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .hit      (hit),
        .len_zero (len_eff == '0),
        .mode     (mode_reg),
        .res0     (res0),
        .res1     (res1),
        .npush    (npush)
    );

    slf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res0       (res0),
        .res1       (res1),
        .npush      (npush),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .status     (fifo_stat)
    );

    assign m_tdata = {4'b0000, head.exit_status, head.print_count, head.match_count,
                      head.line_number, head.print_number, head.print_line};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `SLF_ASSERT_SAME(a_fifo_bound, aclk, aresetn, 1'b1,
        fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
    `SLF_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !fire,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_eos_reg), "input beat lost")
    `SLF_ASSERT_SAME(a_summary_last, aclk, aresetn, m_tvalid && m_tuser,
        m_tlast, "summary beat without last")
    `SLF_ASSERT_SAME(a_number_line, aclk, aresetn, m_tvalid && m_tdata[1],
        m_tdata[0], "line number flagged for an unprinted line")

endmodule

// File: bench/line_verdict_check.sv
`timescale 1ns / 100ps
// Checker for the substring line filter: predicts and compares every result beat.
module line_verdict_check
    import slf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          awaited,
    output int          beats_in,
    output int          verdicts_seen,
    output int          summaries_seen,
    output int          reg_writes
);

    logic [63:0]      pat_lo;
    logic [63:0]      pat_hi;
    logic [4:0]       pat_len_reg;
    logic [3:0]       mode;
    logic [7:0]       window [PATTERN_BYTES];
    int               fill;
    logic             line_found;
    logic             line_has_bytes;
    logic [CNT_W-1:0] lines;
    logic [CNT_W-1:0] chosen;
    int               beats_out;
    result_t          verdict_q [$];

    function automatic int window_len();
        return (pat_len_reg > PATTERN_BYTES) ? PATTERN_BYTES : int'(pat_len_reg);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if ((mode & FLAG_ICASE) != 0 && c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_at(input int k);
        logic [127:0] p;
        p = {pat_hi, pat_lo};
        if (k < 16) begin
            return p[8*k +: 8];
        end
        return 8'd0;
    endfunction

    task automatic clear_line();
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            window[i] = 8'd0;
        end
        fill = 0;
        line_found = 1'b0;
        line_has_bytes = 1'b0;
    endtask

    task automatic judge(input logic last_flag);
        result_t r;
        logic    sel;
        sel = line_found || window_len() == 0;
        if ((mode & FLAG_INVERT) != 0) begin
            sel = !sel;
        end
        if (lines != CNT_MAX) begin
            lines++;
        end
        if (sel && chosen != CNT_MAX) begin
            chosen++;
        end
        r = '0;
        r.kind = KIND_VERDICT;
        r.print_line = sel && (mode & FLAG_COUNT) == 0;
        r.print_number = r.print_line && (mode & FLAG_NUMBER) != 0;
        r.line_number = lines;
        r.match_count = chosen;
        r.last = last_flag;
        verdict_q.push_back(r);
        clear_line();
    endtask

    task automatic take_byte(input logic [7:0] b);
        int   len;
        logic hit;
        len = window_len();
        for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
            window[i] = window[i-1];
        end
        window[0] = b;
        if (fill < PATTERN_BYTES) begin
            fill++;
        end
        line_has_bytes = 1'b1;
        if (len > 0 && fill >= len) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
                if (fold_case(window[len-1-j]) != fold_case(pattern_at(j))) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                line_found = 1'b1;
            end
        end
        if (b == NEWLINE) begin
            judge(1'b1);
        end
    endtask

    task automatic take_end();
        result_t r;
        if (line_has_bytes) begin
            judge(1'b0);
        end
        r = '0;
        r.kind = KIND_SUMMARY;
        r.line_number = lines;
        r.match_count = chosen;
        r.print_count = (mode & FLAG_COUNT) != 0;
        r.exit_status = chosen == 0;
        r.last = 1'b1;
        verdict_q.push_back(r);
        clear_line();
        lines = '0;
        chosen = '0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("Mismatch at result beat %0d: %s, got %0h, wanted %0h",
                     beats_out, what, got, want);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report(name, got, want);
        end
    endtask

    task automatic compare_beat();
        result_t want;
        if (verdict_q.size() == 0) begin
            report("result beat with nothing outstanding", {31'd0, m_tuser}, 32'd0);
        end else begin
            want = verdict_q.pop_front();
            check_field("kind", 32'(m_tuser), 32'(want.kind));
            check_field("print_line", 32'(m_tdata[0]), 32'(want.print_line));
            check_field("print_number", 32'(m_tdata[1]), 32'(want.print_number));
            check_field("line_number", m_tdata[33:2], want.line_number);
            check_field("match_count", m_tdata[65:34], want.match_count);
            check_field("print_count", 32'(m_tdata[66]), 32'(want.print_count));
            check_field("exit_status", 32'(m_tdata[67]), 32'(want.exit_status));
            check_field("last", 32'(m_tlast), 32'(want.last));
            check_field("padding", 32'(m_tdata[71:68]), 32'd0);
            if (want.kind == KIND_SUMMARY) begin
                summaries_seen++;
            end else begin
                verdicts_seen++;
            end
        end
        beats_out++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo = '0;
            pat_hi = '0;
            pat_len_reg = '0;
            mode = '0;
            clear_line();
            lines = '0;
            chosen = '0;
            verdict_q.delete();
            mismatches = 0;
            beats_in = 0;
            beats_out = 0;
            verdicts_seen = 0;
            summaries_seen = 0;
            reg_writes = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_writes++;
                case (reg_idx_t'(paddr[4:3]))
                    REG_PATTERN_LOW: pat_lo = pwdata;
                    REG_PATTERN_HIGH: pat_hi = pwdata;
                    REG_PATTERN_LENGTH: pat_len_reg = pwdata[4:0];
                    REG_MODE_FLAGS: mode = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                beats_in++;
                if (s_tuser == CMD_EOS) begin
                    take_end();
                end else begin
                    take_byte(s_tdata);
                end
            end
            if (m_tvalid && m_tready) begin
                compare_beat();
            end
        end
        awaited <= verdict_q.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the substring line filter bench: clock, reset, register writes, text stimulus and verdict.
module testbench;
    import slf_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 8;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int awaited;
    int beats_in;
    int verdicts_seen;
    int summaries_seen;
    int reg_writes;

    logic [7:0]  cur_pat [PATTERN_BYTES];
    int          cur_len;
    int          burst_left = 0;
    int          sent_items = 0;
    int          idle_cycles = 0;
    int          cycle_no = 0;
    int          rx_left = 0;
    rx_pattern_t rx_pattern = RX_OPEN;

    substring_line_filter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    line_verdict_check verdict_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .awaited        (awaited),
        .beats_in       (beats_in),
        .verdicts_seen  (verdicts_seen),
        .summaries_seen (summaries_seen),
        .reg_writes     (reg_writes)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= $urandom_range(0, 1) == 1;
            RX_SPARSE: m_tready <= $urandom_range(0, 3) == 0;
            default: m_tready <= (cycle_no % 9) < 4;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_beat(CMD_DATA, txt[i]);
        end
    endtask

    // Hold the input back until every predicted beat is out and the pipeline is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(8 * int'(idx));
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len, input logic [3:0] flags);
        settle();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_MODE_FLAGS, 64'(flags));
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            cur_pat[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
        end
        cur_len = (len > PATTERN_BYTES) ? PATTERN_BYTES : int'(len);
    endtask

    function automatic logic [7:0] letter();
        return 8'(($urandom_range(0, 1) == 1) ? 65 : 97) + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (r <= 2 && cur_len > 0) begin
            return cur_pat[$urandom_range(0, cur_len - 1)];
        end
        return letter();
    endfunction

    task automatic pick_setting(input int phase);
        logic [4:0]   len;
        logic [3:0]   flags;
        logic [127:0] pat;
        int           eff;
        flags = 4'($urandom_range(0, 15));
        case (phase)
            0: len = 5'd0;
            1: begin
                len = 5'd16;
                flags = '1;
            end
            2: begin
                len = 5'd31;
                flags = '0;
            end
            3: len = 5'd1;
            default: len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(1, 6));
        endcase
        eff = (len > PATTERN_BYTES) ? PATTERN_BYTES : int'(len);
        for (int k = 0; k < 16; k++) begin
            if (k < eff && $urandom_range(0, 7) != 0) begin
                pat[8*k +: 8] = letter();
            end else begin
                pat[8*k +: 8] = 8'($urandom_range(0, 255));
            end
        end
        if (eff > 0 && $urandom_range(0, 3) == 0) begin
            pat[8*(eff-1) +: 8] = NEWLINE;
        end
        apply_setting(pat[63:0], pat[127:64], len, flags);
    endtask

    // One line of text, with the pattern planted in about half of them.
    task automatic send_line();
        int         n;
        int         at;
        logic [7:0] c;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
        at = (cur_len > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n) : -1;
        for (int i = 0; i <= n; i++) begin
            if (i == at) begin
                for (int k = 0; k < cur_len; k++) begin
                    c = cur_pat[k];
                    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z"
                        && $urandom_range(0, 2) == 0) begin
                        c = c ^ 8'h20;
                    end
                    send_beat(CMD_DATA, c);
                end
            end
            if (i < n) begin
                send_beat(CMD_DATA, text_char());
            end
        end
        case ($urandom_range(0, 19))
            0, 1: send_beat(CMD_EOS, 8'($urandom_range(0, 255)));
            2: ;
            default: send_beat(CMD_DATA, NEWLINE);
        endcase
    endtask

    initial begin
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tuser <= CMD_DATA;
        s_tdata <= '0;
        cur_len = 0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            cur_pat[k] = 8'd0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings out of reset: the empty pattern selects every line, then an empty stream.
        send_beat(CMD_DATA, 8'h00);
        send_beat(CMD_DATA, 8'hFF);
        send_beat(CMD_DATA, NEWLINE);
        send_beat(CMD_EOS, 8'h00);
        send_beat(CMD_EOS, 8'hFF);

        // A pattern that ends in the newline matches at the end of its line.
        apply_setting({48'd0, NEWLINE, 8'h62}, 64'd0, 5'd2, FLAG_NUMBER);
        send_text("ab\nx\n");

        // Over-long length with all-ones bytes, every mode bit, unterminated line at the end.
        apply_setting('1, '1, 5'd31, FLAG_INVERT | FLAG_COUNT | FLAG_NUMBER | FLAG_ICASE);
        send_beat(CMD_DATA, 8'hFF);
        send_beat(CMD_DATA, 8'hFF);
        send_beat(CMD_DATA, 8'h00);
        send_beat(CMD_DATA, 8'hFF);
        send_beat(CMD_EOS, 8'hFF);

        // Case folding switched on halfway through a line.
        apply_setting({48'd0, 8'h42, 8'h61}, 64'd0, 5'd2, '0);
        send_text("a");
        settle();
        write_reg(REG_MODE_FLAGS, 64'(FLAG_ICASE));
        send_text("b\n");
        send_beat(CMD_EOS, 8'h5A);

        for (int phase = 0; phase < PHASES; phase++) begin
            pick_setting(phase);
            while (sent_items < 19 + (phase + 1) * (RANDOM_ITEMS / PHASES)) begin
                send_line();
            end
        end

        settle();
        $display("Covered %0d input beats over %0d register writes and %0d random phases.",
                 beats_in, reg_writes, PHASES);
        $display("Checked %0d line verdicts and %0d stream summaries, %0d mismatches.",
                 verdicts_seen, summaries_seen, mismatches);
        if (mismatches == 0 && awaited == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: substring_line_filter_core.f
+incdir+design
design/slf_pkg.sv
design/slf_window.sv
design/slf_judge.sv
design/slf_fifo.sv
design/substring_line_filter_core.sv
bench/line_verdict_check.sv
bench/testbench.sv
